>>> hdl/nrss_pkg.sv
// Shared constants and helpers for the NR sync sequence generator.
// Holds the base m-sequences, identity reduction constants and the rotate function.
// No dependencies.
package nrss_pkg;

  localparam int SEQ_LEN = 127;
  localparam int SHIFT_W = 7;
  localparam int CHIP_W  = 32;
  localparam int FIRST_W = 7;
  localparam int COUNT_W = 6;
  localparam int GROUP_W = 9;
  localparam int SECTOR_W = 2;

  // identity reduction
  localparam logic [GROUP_W-1:0]  GROUP_MOD    = 9'd336;
  localparam logic [GROUP_W-1:0]  GROUP_SPLIT  = 9'd112;
  localparam logic [GROUP_W-1:0]  GROUP_SPLIT2 = 9'd224;
  localparam logic [SECTOR_W-1:0] SECTOR_MOD   = 2'd3;

  // cyclic shift steps
  localparam logic [SHIFT_W-1:0] PSS_STEP       = 7'd43;
  localparam logic [SHIFT_W-1:0] M0_GROUP_STEP  = 7'd15;
  localparam logic [SHIFT_W-1:0] M0_SECTOR_STEP = 7'd5;

  // request codes
  localparam logic REQ_PSS = 1'b0;
  localparam logic REQ_SSS = 1'b1;

  typedef logic [SEQ_LEN-1:0] chip_vec_t;

  // x(i+7) = x(i+7-tap) ^ x(i); bit i of init is x(i)
  function automatic chip_vec_t gen_mseq(input logic [6:0] init, input int tap);
    chip_vec_t x;
    x = '0;
    x[6:0] = init;
    for (int i = 7; i < SEQ_LEN; i++) begin
      x[i] = x[i-tap] ^ x[i-7];
    end
    return x;
  endfunction

  localparam chip_vec_t PSS_BASE  = gen_mseq(7'b1110110, 3);
  localparam chip_vec_t SSS0_BASE = gen_mseq(7'b0000001, 3);
  localparam chip_vec_t SSS1_BASE = gen_mseq(7'b0000001, 6);

  // result bit n = x[(n + sh) mod 127], sh below 127
  function automatic chip_vec_t rotate(input chip_vec_t x, input logic [SHIFT_W-1:0] sh);
    logic [2*SEQ_LEN-1:0] d;
    d = {x, x} >> sh;
    return d[SEQ_LEN-1:0];
  endfunction

endpackage

>>> hdl/nr_sync_sequence_generator.sv
// NR primary / secondary sync sequence generator, top level.
// Depends on nrss_pkg for the base m-sequences and reduction constants.
// Single module: request decode, sequence register, chunk output register.
//
// Usage
//   Input channel (in_valid / in_ready) carries one request item: req_type
//   selects primary (0) or secondary (1) sequence, cell_group and cell_sector
//   give the identity parts (wrapped mod 336 and mod 3).
//   Output channel (out_valid / out_ready) returns the 127 chips of that
//   sequence as ceil(127 / CHIPS_PER_RESULT) chunk items, least significant
//   chip first; a chip bit of 1 means -1. first_chip, chip_count and last
//   describe each chunk; chips above chip_count read as zero.
// Path: a request is taken into the sequence register, and its chunks then
//   leave through the output register.
// Throughput: one chunk per cycle while out_ready is high; a request gives
//   ceil(127 / CHIPS_PER_RESULT) chunks (4 at the default of 32). The rate is set by the single chunk
//   output register, which moves one chunk per cycle while it is not stalled.
// The next request is taken in the same cycle the last chunk of the current
//   one moves into the output register, so requests run back to back.
// Stall: when out_ready is low the output register holds its chunk and the
//   sequence register holds its place; in_ready drops once that is full.
// Reset (rst, synchronous, active high) empties both stages; nothing is kept
//   between requests.
module nr_sync_sequence_generator #(
  parameter int CHIPS_PER_RESULT = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [8:0]  cell_group,
  input  logic [1:0]  cell_sector,
  // chunk channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] chips,
  output logic [6:0]  first_chip,
  output logic [5:0]  chip_count,
  output logic        last
);

  localparam int NumChunks = (nrss_pkg::SEQ_LEN + CHIPS_PER_RESULT - 1) / CHIPS_PER_RESULT;
  localparam int IdxW      = (NumChunks > 1) ? $clog2(NumChunks) : 1;

  // ---------------------------------------------------------------------------
  // Request decode: identity reduction and full sequence
  // ---------------------------------------------------------------------------
  logic [1:0]                        n2;
  logic [8:0]                        n1;
  logic [1:0]                        grp_q;    // n1 / 112
  logic [8:0]                        grp_base; // 112 * grp_q
  logic [nrss_pkg::SHIFT_W-1:0]      m0;
  logic [nrss_pkg::SHIFT_W-1:0]      m1;
  logic [nrss_pkg::SHIFT_W-1:0]      pss_sh;
  nrss_pkg::chip_vec_t               new_seq;

  always_comb begin
    n2 = (cell_sector == nrss_pkg::SECTOR_MOD) ? 2'd0 : cell_sector;
    n1 = (cell_group >= nrss_pkg::GROUP_MOD) ? (cell_group - nrss_pkg::GROUP_MOD) : cell_group;

    priority if (n1 >= nrss_pkg::GROUP_SPLIT2) begin
      grp_q    = 2'd2;
      grp_base = nrss_pkg::GROUP_SPLIT2;
    end else if (n1 >= nrss_pkg::GROUP_SPLIT) begin
      grp_q    = 2'd1;
      grp_base = nrss_pkg::GROUP_SPLIT;
    end else begin
      grp_q    = 2'd0;
      grp_base = '0;
    end

    m1     = 7'(n1 - grp_base);
    m0     = 7'(nrss_pkg::M0_GROUP_STEP * 7'(grp_q) + nrss_pkg::M0_SECTOR_STEP * 7'(n2));
    pss_sh = 7'(nrss_pkg::PSS_STEP * 7'(n2));   // 0, 43 or 86

    if (req_type == nrss_pkg::REQ_SSS) begin
      new_seq = nrss_pkg::rotate(nrss_pkg::SSS0_BASE, m0)
              ^ nrss_pkg::rotate(nrss_pkg::SSS1_BASE, m1);
    end else begin
      new_seq = nrss_pkg::rotate(nrss_pkg::PSS_BASE, pss_sh);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence register and chunk counter
  // ---------------------------------------------------------------------------
  logic                 hold_valid;
  nrss_pkg::chip_vec_t  seq_bits;
  logic [IdxW-1:0]      chunk_idx;
  logic                 idx_last;
  logic                 load_out;
  logic                 in_acc;

  assign idx_last = (chunk_idx == IdxW'(NumChunks - 1));
  assign load_out = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || (load_out && idx_last);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      chunk_idx  <= '0;
    end else if (in_acc) begin
      hold_valid <= 1'b1;
      chunk_idx  <= '0;
    end else if (load_out && idx_last) begin
      hold_valid <= 1'b0;
    end else if (load_out) begin
      chunk_idx  <= chunk_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      seq_bits <= new_seq;
    end
  end

  // ---------------------------------------------------------------------------
  // Chunk extraction
  // ---------------------------------------------------------------------------
  logic [7:0]                 start;
  logic [7:0]                 remain;
  logic [7:0]                 len;
  nrss_pkg::chip_vec_t        shifted;
  logic [nrss_pkg::CHIP_W-1:0] chunk_word;

  always_comb begin
    start   = 8'(int'(chunk_idx) * CHIPS_PER_RESULT);
    remain  = 8'(nrss_pkg::SEQ_LEN) - start;
    len     = (remain > 8'(CHIPS_PER_RESULT)) ? 8'(CHIPS_PER_RESULT) : remain;
    shifted = seq_bits >> start;
    for (int b = 0; b < nrss_pkg::CHIP_W; b++) begin
      chunk_word[b] = (8'(b) < len) && shifted[b];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      chips      <= chunk_word;
      first_chip <= start[6:0];
      chip_count <= len[5:0];
      last       <= idx_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a request is only taken over a busy sequence register as its last chunk leaves
  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    (in_acc && hold_valid) |-> (load_out && idx_last))
    else $error("request accepted while chunks still pending");

  // the last chunk ends exactly at the sequence end
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> ((8'(first_chip) + 8'(chip_count)) == 8'(nrss_pkg::SEQ_LEN)))
    else $error("last chunk does not close the sequence");

  // a taken non-final chunk is followed at once by the next chunk of the same item
  a_chunk_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && first_chip == 7'($past(first_chip) + 7'(CHIPS_PER_RESULT))))
    else $error("chunk sequence broken");

endmodule
